### rtl/osig_pkg.sv
// ----------------------------------------------------------------------------
// osig_pkg
// Shared types and constants of the octahedron sphere index generator.
// ----------------------------------------------------------------------------
package osig_pkg;

  localparam int unsigned MAX_SUBDIVISION = 6;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned RING_W = 7;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned ADDR_W = 3;

  localparam logic REG_SUBDIVISION_LEVEL = 1'b0;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST = 2'd2;
  localparam logic [1:0] SIDE_LAST = 2'd3;

  typedef enum logic [2:0] {
    BAND_LOWER = 3'b001,
    BAND_UPPER = 3'b010,
    BAND_CAP   = 3'b100
  } osig_band_t;

  typedef struct packed {
    osig_band_t          band_phase;
    logic [RING_W-1:0]   ring_number;
    logic [1:0]          side_number;
    logic [RING_W-1:0]   strip_step;
    logic                pair_half;
    logic [1:0]          corner_count;
    logic [INDEX_W-1:0]  top_base;
    logic [INDEX_W-1:0]  bottom_base;
    logic [INDEX_W-1:0]  next_vertex;
  } osig_state_t;

  localparam osig_state_t OSIG_START = '{
    band_phase:   BAND_LOWER,
    ring_number:  7'd1,
    side_number:  2'd0,
    strip_step:   7'd0,
    pair_half:    1'b0,
    corner_count: 2'd0,
    top_base:     16'd5,
    bottom_base:  16'd0,
    next_vertex:  16'd5
  };

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic [1:0]         corner;
    logic               last_of_mesh;
  } osig_result_t;

endpackage

### rtl/osig_step.sv
// ----------------------------------------------------------------------------
// osig_step
// Next-state and result logic for one index of the mesh walk.
// ----------------------------------------------------------------------------
module osig_step import osig_pkg::*; (
  input  osig_state_t         cur,
  input  logic                restart,
  input  logic [LEVEL_W-1:0]  level,
  output osig_state_t         nxt,
  output osig_result_t        result
);

  function automatic osig_state_t end_side(osig_state_t s, logic [RING_W-1:0] r);
    osig_state_t        e;
    logic [INDEX_W-1:0] nv;
    logic [RING_W-1:0]  i;
    logic               to_cap;
    i = s.ring_number;
    nv = s.next_vertex + INDEX_W'(i);
    e = s;
    to_cap = 1'b0;
    e.next_vertex = nv;
    if (s.side_number != SIDE_LAST) begin
      e.side_number = s.side_number + 2'd1;
      e.strip_step = '0;
      e.top_base = nv;
      if (s.band_phase == BAND_LOWER) begin
        e.pair_half = 1'b0;
        if (i == 7'd1) begin
          e.bottom_base = s.bottom_base + 16'd1;
        end
      end else begin
        e.pair_half = 1'b1;
      end
    end else begin
      if (s.band_phase == BAND_LOWER) begin
        if (i < r) begin
          e.ring_number = i + 7'd1;
        end else if (r > 7'd1) begin
          e.band_phase = BAND_UPPER;
          e.ring_number = r - 7'd1;
        end else begin
          to_cap = 1'b1;
        end
      end else begin
        if (i > 7'd1) begin
          e.ring_number = i - 7'd1;
        end else begin
          to_cap = 1'b1;
        end
      end
      e.side_number = '0;
      e.strip_step = '0;
      e.bottom_base = nv - 16'd1 - {7'b0, i, 2'b00};
      if (to_cap) begin
        e.band_phase = BAND_CAP;
        e.pair_half = 1'b0;
        e.top_base = nv;
      end else begin
        e.pair_half = (e.band_phase == BAND_UPPER);
        e.next_vertex = nv + 16'd1;
        e.top_base = nv + 16'd1;
      end
    end
    return e;
  endfunction

  osig_state_t         s;
  osig_state_t         stepped;
  osig_state_t         side_in;
  osig_state_t         side_out;
  logic [1:0]          c;
  logic [LEVEL_W-1:0]  level_sat;
  logic [RING_W-1:0]   ring_limit;
  logic [INDEX_W-1:0]  vt;
  logic [INDEX_W-1:0]  vb;
  logic [INDEX_W-1:0]  t0;
  logic [INDEX_W-1:0]  t1;
  logic [INDEX_W-1:0]  t2;

  always_comb begin
    s = restart ? OSIG_START : cur;
    c = (s.corner_count > CORNER_LAST) ? CORNER_LAST : s.corner_count;
    level_sat = (level > LEVEL_W'(MAX_SUBDIVISION)) ? LEVEL_W'(MAX_SUBDIVISION) : level;
    ring_limit = 7'd1 << level_sat;
    vt = s.top_base;
    vb = s.bottom_base;

    t0 = vb;
    t1 = vt;
    t2 = vb + 16'd1;
    unique case (s.band_phase)
      BAND_LOWER: begin
        if (!s.pair_half) begin
          t1 = vt - 16'd1;
          t2 = vt;
        end
      end
      BAND_UPPER: begin
        if (s.pair_half && s.strip_step == '0) begin
          t1 = vt - 16'd1;
        end else if (!s.pair_half) begin
          t0 = vt - 16'd1;
          t1 = vt;
          t2 = vb;
        end
      end
      default: begin
      end
    endcase

    unique case (c)
      2'd0:    result.vertex_index = t0;
      2'd1:    result.vertex_index = t1;
      default: result.vertex_index = t2;
    endcase
    result.corner = c;
    result.last_of_mesh = (s.band_phase == BAND_CAP) && (s.side_number == SIDE_LAST) &&
                          (c == CORNER_LAST);

    // The upper band closes a side only after both bases have advanced.
    stepped = s;
    stepped.top_base = s.top_base + 16'd1;
    stepped.bottom_base = s.bottom_base + 16'd1;
    side_in = (s.band_phase == BAND_UPPER) ? stepped : s;
    side_out = end_side(side_in, ring_limit);

    nxt = s;
    if (c != CORNER_LAST) begin
      nxt.corner_count = c + 2'd1;
    end else begin
      nxt.corner_count = CORNER_FIRST;
      unique case (s.band_phase)
        BAND_LOWER: begin
          if (!s.pair_half) begin
            if (({1'b0, s.strip_step} + 8'd1) >= {1'b0, s.ring_number}) begin
              nxt = side_out;
              nxt.corner_count = CORNER_FIRST;
            end else begin
              nxt.pair_half = 1'b1;
            end
          end else begin
            nxt.pair_half = 1'b0;
            nxt.strip_step = s.strip_step + 7'd1;
            nxt.top_base = stepped.top_base;
            nxt.bottom_base = stepped.bottom_base;
          end
        end
        BAND_UPPER: begin
          if (s.pair_half && s.strip_step == '0) begin
            nxt.bottom_base = stepped.bottom_base;
            nxt.pair_half = 1'b0;
            nxt.strip_step = 7'd1;
          end else if (!s.pair_half) begin
            nxt.pair_half = 1'b1;
          end else if (s.strip_step >= s.ring_number) begin
            nxt = side_out;
            nxt.corner_count = CORNER_FIRST;
          end else begin
            nxt = stepped;
            nxt.corner_count = CORNER_FIRST;
            nxt.strip_step = s.strip_step + 7'd1;
            nxt.pair_half = 1'b0;
          end
        end
        default: begin
          if (s.side_number == SIDE_LAST) begin
            nxt = OSIG_START;
          end else begin
            nxt = stepped;
            nxt.corner_count = CORNER_FIRST;
            nxt.side_number = s.side_number + 2'd1;
          end
        end
      endcase
    end
  end

endmodule

### rtl/octahedron_sphere_index_generator_top.sv
// ----------------------------------------------------------------------------
// octahedron_sphere_index_generator_top
// A result word is registered when its input word is accepted and is valid in the next cycle.
// Throughput: one word per cycle while the result is not stalled; a stalled result word holds the input stall.
// Reset: synchronous, clears the walk to its start and the level to zero.
// A level write also restarts the walk.
// ----------------------------------------------------------------------------
module octahedron_sphere_index_generator_top import osig_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                restart,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [INDEX_W-1:0]  vertex_index,
  output logic [1:0]          corner,
  output logic                last_of_mesh
);

  osig_state_t         st;
  osig_state_t         st_next;
  osig_result_t        res_next;
  logic [LEVEL_W-1:0]  level;
  logic                item_accept;
  logic                cfg_write;

  osig_step u_step (
    .cur     (st),
    .restart (restart),
    .level   (level),
    .nxt     (st_next),
    .result  (res_next)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SUBDIVISION_LEVEL) ? {29'b0, level} : 32'b0;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == REG_SUBDIVISION_LEVEL);

  assign item_stall = result_valid && result_stall;
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= OSIG_START;
      level <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        level <= pwdata[LEVEL_W-1:0];
        st <= OSIG_START;
      end else if (item_accept) begin
        st <= st_next;
      end
      if (item_accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      vertex_index <= res_next.vertex_index;
      corner <= res_next.corner;
      last_of_mesh <= res_next.last_of_mesh;
    end
  end

  a_ring_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.ring_number != 7'd0)
    else $error("ring counter reached zero");

  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    st.corner_count != 2'd3)
    else $error("corner counter out of range");

  a_last_on_corner: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_mesh |-> corner == CORNER_LAST)
    else $error("last index flagged on a corner other than the final one");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with an empty result register");

endmodule
